// ===== hw/rtl/linear_blend_skinning_unit_assert.svh =====
// ----------------------------------------------------------------------------
// skinning unit assertion macros
// concurrent checks on clk, disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef LINEAR_BLEND_SKINNING_UNIT_ASSERT_SVH
`define LINEAR_BLEND_SKINNING_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define LBS_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("skinning unit check failed");

`define LBS_ASSERT_NEXT(lbl, cond, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
	else $error("skinning unit check failed");

`else

`define LBS_ASSERT(lbl, prop)
`define LBS_ASSERT_NEXT(lbl, cond, prop)

`endif

`endif

// ===== hw/rtl/lbs_pkg.sv =====
// ----------------------------------------------------------------------------
// lbs_pkg
// constants and codes shared by the skinning unit and its testbench
// ----------------------------------------------------------------------------
package lbs_pkg;

	localparam int JOINT_COUNT = 128;
	localparam int FRAC_BITS   = 16;
	localparam int WEIGHT_BITS = 16;
	localparam int MAT_ELEMS   = 12;
	localparam int STORE_DEPTH = JOINT_COUNT * MAT_ELEMS;
	localparam int JOINT_W     = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;
	localparam int SHIFT       = FRAC_BITS + WEIGHT_BITS;

	// divide-by-twelve of an 11-bit address: (addr * 2731) >> 15
	localparam int DIV12_MUL = 2731;
	localparam int DIV12_SH  = 15;

	localparam int PROD_W  = 50;
	localparam int BLEND_W = 51;
	localparam int LO_W    = 26;
	localparam int HI_W    = BLEND_W - LO_W;
	localparam int TERM_W  = 83;
	localparam int SUM_W   = 85;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_SKIN  = 1'b1;

endpackage

// ===== hw/rtl/lbs_if.sv =====
// ----------------------------------------------------------------------------
// lbs channel interfaces
// valid/ready channels for command beats and skinned position beats
// ----------------------------------------------------------------------------
interface lbs_in_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic [10:0] matrix_addr;
	logic [31:0] matrix_word;
	logic [31:0] pos_x;
	logic [31:0] pos_y;
	logic [31:0] pos_z;
	logic [27:0] joint_set;
	logic [16:0] weight0;
	logic [16:0] weight1;
	logic [16:0] weight2;
	logic [16:0] weight3;

	modport source (output valid, cmd, matrix_addr, matrix_word, pos_x, pos_y, pos_z,
		joint_set, weight0, weight1, weight2, weight3, input ready);
	modport sink (input valid, cmd, matrix_addr, matrix_word, pos_x, pos_y, pos_z,
		joint_set, weight0, weight1, weight2, weight3, output ready);
endinterface

interface lbs_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] out_x;
	logic [31:0] out_y;
	logic [31:0] out_z;
	logic        saturated;

	modport source (output valid, out_x, out_y, out_z, saturated, input ready);
	modport sink (input valid, out_x, out_y, out_z, saturated, output ready);
endinterface

// ===== hw/rtl/linear_blend_skinning_unit.sv =====
// ----------------------------------------------------------------------------
// linear blend skinning unit
// four-influence vertex skinning in fixed point with an on-chip matrix store
// ----------------------------------------------------------------------------
// A vertex beat is sequenced over its four influences: the matrix store is read
// one joint row (all twelve words) per cycle while the pipe is not held, once
// for each influence. A matrix write beat is accepted only between vertices.
// Results leave through the pipe stages and the output register, in order.
// The store holds nothing valid after reset; every joint a vertex names must
// be written first.
`include "linear_blend_skinning_unit_assert.svh"

module linear_blend_skinning_unit import lbs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_wr_en,
	input  logic cfg_wr_data,
	lbs_in_if.sink    req,
	lbs_out_if.source rsp
);

	logic enable_q;
	logic en;
	logic accept, skin_acc, wr_acc;
	logic busy_q;
	logic [1:0] ph_q;

	logic [22:0] div_prod;
	logic [7:0]  wr_joint;
	logic [3:0]  wr_elem;

	logic [MAT_ELEMS-1:0][31:0] skin_mem_q [JOINT_COUNT];

	// vertex under sequencing
	logic signed [31:0] pos_q [3];
	logic [27:0]        joints_q;
	logic [3:0][16:0]   w_q;
	logic               pass_q;
	logic [6:0]         jsel;
	logic               jok;

	// stage 1: row read
	logic                       vld_s1, first_s1, last_s1, jok_s1, pass_s1;
	logic [MAT_ELEMS-1:0][31:0] rd_s1;
	logic [16:0]                w_s1;
	logic signed [31:0]         pos_s1 [3];

	// stage 2: weighted row
	logic                      vld_s2, first_s2, last_s2, pass_s2;
	logic signed [PROD_W-1:0]  prod_c [MAT_ELEMS];
	logic signed [PROD_W-1:0]  prod_s2 [MAT_ELEMS];
	logic signed [31:0]        pos_s2 [3];

	// stage 3: blended matrix
	logic                      vld_s3, pass_s3;
	logic signed [BLEND_W-1:0] blend_s3 [MAT_ELEMS];
	logic signed [31:0]        pos_s3 [3];

	// stage 4: partial products
	logic                        vld_s4, pass_s4;
	logic signed [LO_W+32:0]     lo_s4 [3][3];
	logic signed [HI_W+31:0]     hi_s4 [3][3];
	logic signed [BLEND_W-1:0]   c3_s4 [3];
	logic signed [31:0]          pos_s4 [3];

	// stage 5: full products
	logic                      vld_s5, pass_s5;
	logic signed [TERM_W-1:0]  term_s5 [3][4];
	logic signed [31:0]        pos_s5 [3];

	// stage 6: row sums
	logic                      vld_s6, pass_s6;
	logic signed [SUM_W-1:0]   sum_s6 [3];
	logic signed [31:0]        pos_s6 [3];

	// output register
	logic        out_valid_q;
	logic [31:0] out_q [3];
	logic        sat_q;
	logic signed [SUM_W-1:0] shifted [3];
	logic [31:0] clamp_c [3];
	logic [2:0]  sat_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b1;
		end else if (cfg_wr_en) begin
			enable_q <= cfg_wr_data;
		end
	end

	// whole pipe holds only when a result waits on a full output
	assign en        = !out_valid_q || rsp.ready || !vld_s6;
	assign req.ready = en && (!busy_q || ph_q == 2'd3);
	assign accept    = req.valid && req.ready;
	assign skin_acc  = accept && req.cmd == CMD_SKIN;
	assign wr_acc    = accept && req.cmd == CMD_WRITE && int'(req.matrix_addr) < STORE_DEPTH;

	assign div_prod = 23'(req.matrix_addr) * 23'(DIV12_MUL);
	assign wr_joint = div_prod[22:DIV12_SH];
	assign wr_elem  = 4'(req.matrix_addr - 11'(wr_joint) * 11'(MAT_ELEMS));

	always_ff @(posedge clk) begin
		if (wr_acc) begin
			skin_mem_q[JOINT_W'(wr_joint)][wr_elem] <= req.matrix_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ph_q   <= 2'd0;
		end else if (en) begin
			if (busy_q && ph_q != 2'd3) begin
				ph_q <= ph_q + 2'd1;
			end else begin
				ph_q   <= 2'd0;
				busy_q <= skin_acc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skin_acc) begin
			pos_q[0] <= req.pos_x;
			pos_q[1] <= req.pos_y;
			pos_q[2] <= req.pos_z;
			joints_q <= req.joint_set;
			w_q      <= {req.weight3, req.weight2, req.weight1, req.weight0};
			pass_q   <= !enable_q;
		end
	end

	assign jsel = joints_q[7 * ph_q +: 7];
	assign jok  = int'(jsel) < JOINT_COUNT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s1 <= busy_q;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2 && last_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rd_s1    <= skin_mem_q[JOINT_W'(jsel)];
			w_s1     <= w_q[ph_q];
			jok_s1   <= jok;
			first_s1 <= ph_q == 2'd0;
			last_s1  <= ph_q == 2'd3;
			pass_s1  <= pass_q;
			pos_s1   <= pos_q;
		end
	end

	always_comb begin
		for (int e = 0; e < MAT_ELEMS; e++) begin
			prod_c[e] = $signed({1'b0, w_s1}) * $signed(rd_s1[e]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int e = 0; e < MAT_ELEMS; e++) begin
				prod_s2[e] <= jok_s1 ? prod_c[e] : '0;
			end
			first_s2 <= first_s1;
			last_s2  <= last_s1;
			pass_s2  <= pass_s1;
			pos_s2   <= pos_s1;
		end
	end

	// blend accumulates over the four influences
	always_ff @(posedge clk) begin
		if (en && vld_s2) begin
			for (int e = 0; e < MAT_ELEMS; e++) begin
				if (first_s2) begin
					blend_s3[e] <= BLEND_W'(prod_s2[e]);
				end else begin
					blend_s3[e] <= blend_s3[e] + BLEND_W'(prod_s2[e]);
				end
			end
			pass_s3 <= pass_s2;
			pos_s3  <= pos_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					lo_s4[r][c] <= $signed({1'b0, blend_s3[r*4+c][LO_W-1:0]}) * pos_s3[c];
					hi_s4[r][c] <= $signed(blend_s3[r*4+c][BLEND_W-1:LO_W]) * pos_s3[c];
				end
				c3_s4[r] <= blend_s3[r*4+3];
			end
			pass_s4 <= pass_s3;
			pos_s4  <= pos_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					term_s5[r][c] <= (TERM_W'(hi_s4[r][c]) <<< LO_W) + TERM_W'(lo_s4[r][c]);
				end
				term_s5[r][3] <= TERM_W'(c3_s4[r]) <<< FRAC_BITS;
			end
			pass_s5 <= pass_s4;
			pos_s5  <= pos_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				sum_s6[r] <= SUM_W'(term_s5[r][0]) + SUM_W'(term_s5[r][1])
					+ SUM_W'(term_s5[r][2]) + SUM_W'(term_s5[r][3]);
			end
			pass_s6 <= pass_s5;
			pos_s6  <= pos_s5;
		end
	end

	// floor shift, then clamp to 32 bits
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			shifted[r] = sum_s6[r] >>> SHIFT;
			if ((&shifted[r][SUM_W-1:31]) || !(|shifted[r][SUM_W-1:31])) begin
				clamp_c[r] = shifted[r][31:0];
				sat_c[r]   = 1'b0;
			end else begin
				clamp_c[r] = shifted[r][SUM_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
				sat_c[r]   = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en && vld_s6) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en && vld_s6) begin
			for (int r = 0; r < 3; r++) begin
				out_q[r] <= pass_s6 ? pos_s6[r] : clamp_c[r];
			end
			sat_q <= !pass_s6 && (|sat_c);
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.out_x     = out_q[0];
	assign rsp.out_y     = out_q[1];
	assign rsp.out_z     = out_q[2];
	assign rsp.saturated = sat_q;

	`LBS_ASSERT(a_idle_phase, !busy_q |-> ph_q == 2'd0)
	`LBS_ASSERT_NEXT(a_stall_holds, vld_s6 && out_valid_q && !rsp.ready, vld_s6 && out_valid_q)
	`LBS_ASSERT_NEXT(a_blend_done, en && vld_s2 && last_s2, vld_s3)
	`LBS_ASSERT(a_no_accept_mid_vertex, busy_q && ph_q != 2'd3 |-> !req.ready)

endmodule

// ===== dv/linear_blend_skinning_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// linear blend skinning unit testbench
// fills the joint matrix store, sends vertex beats with random gaps and
// checks every skinned position against an in-bench blend-and-transform
// predictor, across skinning enable settings and output back-pressure
// ----------------------------------------------------------------------------
module linear_blend_skinning_unit_tb;
	import lbs_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 16;
	localparam int LONG_HOLD      = 400;

	typedef struct {
		logic        cmd;
		logic [10:0] matrix_addr;
		logic [31:0] matrix_word;
		logic [31:0] pos_x;
		logic [31:0] pos_y;
		logic [31:0] pos_z;
		logic [27:0] joint_set;
		logic [16:0] weight [4];
	} cmd_beat_t;

	typedef struct {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic        sat;
	} position_t;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic cfg_wr_data;

	lbs_in_if  req ();
	lbs_out_if rsp ();

	linear_blend_skinning_unit DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.req         (req.sink),
		.rsp         (rsp.source)
	);

	cmd_beat_t   pending_beats[$];
	position_t   expected_positions[$];
	logic [31:0] skin_words [STORE_DEPTH];
	logic        blend_on;
	logic [11:0] joint_filled [JOINT_COUNT];
	int          complete_joints[$];
	int          error_count;
	int          vertex_count;
	int          write_count;
	int          sat_count;
	int          checked_count;
	int          idle_cycles;
	int          beats_queued;
	int          in_gap;
	int          out_gap;
	int          hold_count;
	bit          hold_done;
	bit          burst_mode;

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	function automatic position_t skin_vertex(cmd_beat_t b);
		logic signed [127:0] blend [12];
		logic signed [127:0] pos [4];
		logic signed [127:0] wv;
		logic signed [127:0] mv;
		logic signed [127:0] acc;
		logic signed [127:0] lim_hi;
		logic signed [127:0] lim_lo;
		logic [31:0]         coord [3];
		int                  j;
		position_t           p;
		p.sat = 1'b0;
		if (!blend_on) begin
			p.x = b.pos_x;
			p.y = b.pos_y;
			p.z = b.pos_z;
			return p;
		end
		lim_hi = 128'sh7FFF_FFFF;
		lim_lo = -128'sh8000_0000;
		pos[0] = $signed(b.pos_x);
		pos[1] = $signed(b.pos_y);
		pos[2] = $signed(b.pos_z);
		pos[3] = 128'sd1 <<< FRAC_BITS;
		for (int e = 0; e < 12; e++)
			blend[e] = '0;
		for (int k = 0; k < 4; k++) begin
			j = b.joint_set[7*k +: 7];
			if (j >= JOINT_COUNT)
				continue;
			wv = {111'd0, b.weight[k]};
			for (int e = 0; e < 12; e++) begin
				mv = $signed(skin_words[j*12 + e]);
				blend[e] = blend[e] + wv * mv;
			end
		end
		for (int r = 0; r < 3; r++) begin
			acc = '0;
			for (int c = 0; c < 4; c++)
				acc = acc + blend[r*4 + c] * pos[c];
			acc = acc >>> SHIFT;
			if (acc > lim_hi) begin
				coord[r] = 32'h7FFF_FFFF;
				p.sat = 1'b1;
			end else if (acc < lim_lo) begin
				coord[r] = 32'h8000_0000;
				p.sat = 1'b1;
			end else begin
				coord[r] = acc[31:0];
			end
		end
		p.x = coord[0];
		p.y = coord[1];
		p.z = coord[2];
		return p;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h want %h (result %0d)", what, got, want, checked_count);
		error_count++;
	endtask

	function automatic int pick_gap();
		int r;
		if (burst_mode)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(5, 30);
	endfunction

	// driver: accepted beats update the predictor
	always @(posedge clk or negedge arst_n) begin
		cmd_beat_t b;
		if (!arst_n) begin
			req.valid       <= 1'b0;
			req.cmd         <= CMD_WRITE;
			req.matrix_addr <= '0;
			req.matrix_word <= '0;
			req.pos_x       <= '0;
			req.pos_y       <= '0;
			req.pos_z       <= '0;
			req.joint_set   <= '0;
			req.weight0     <= '0;
			req.weight1     <= '0;
			req.weight2     <= '0;
			req.weight3     <= '0;
			in_gap          <= 0;
		end else begin
			if (req.valid && req.ready) begin
				b = pending_beats.pop_front();
				if (b.cmd == CMD_WRITE) begin
					write_count++;
					if (b.matrix_addr < STORE_DEPTH)
						skin_words[b.matrix_addr] = b.matrix_word;
				end else begin
					vertex_count++;
					expected_positions.insert(expected_positions.size(), skin_vertex(b));
				end
			end
			if (!(req.valid && !req.ready)) begin
				if (in_gap > 0) begin
					in_gap    <= in_gap - 1;
					req.valid <= 1'b0;
				end else if (pending_beats.size() > 0) begin
					b = pending_beats[0];
					req.valid       <= 1'b1;
					req.cmd         <= b.cmd;
					req.matrix_addr <= b.matrix_addr;
					req.matrix_word <= b.matrix_word;
					req.pos_x       <= b.pos_x;
					req.pos_y       <= b.pos_y;
					req.pos_z       <= b.pos_z;
					req.joint_set   <= b.joint_set;
					req.weight0     <= b.weight[0];
					req.weight1     <= b.weight[1];
					req.weight2     <= b.weight[2];
					req.weight3     <= b.weight[3];
					in_gap          <= pick_gap();
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	// monitor: checks result beats, stalls at random, one long hold
	always @(posedge clk or negedge arst_n) begin
		position_t p;
		if (!arst_n) begin
			rsp.ready  <= 1'b0;
			out_gap    <= 0;
			hold_count <= 0;
			hold_done  <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				checked_count++;
				if (expected_positions.size() == 0) begin
					report("unexpected beat", rsp.out_x, 32'd0);
				end else begin
					p = expected_positions.pop_front();
					if (p.sat)
						sat_count++;
					if (rsp.out_x !== p.x)
						report("out_x", rsp.out_x, p.x);
					if (rsp.out_y !== p.y)
						report("out_y", rsp.out_y, p.y);
					if (rsp.out_z !== p.z)
						report("out_z", rsp.out_z, p.z);
					if (rsp.saturated !== p.sat)
						report("saturated", {31'd0, rsp.saturated}, {31'd0, p.sat});
				end
			end
			if (!hold_done && checked_count >= 60) begin
				hold_done  <= 1'b1;
				hold_count <= LONG_HOLD;
				rsp.ready  <= 1'b0;
			end else if (hold_count > 0) begin
				hold_count <= hold_count - 1;
				rsp.ready  <= 1'b0;
			end else if (out_gap > 0) begin
				out_gap   <= out_gap - 1;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= 1'b1;
				out_gap   <= pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no beat for %0d cycles", idle_cycles);
			$display("** linear_blend_skinning_unit: FAILED **");
			$finish;
		end
	end

	task automatic push_write(int addr, logic [31:0] word);
		cmd_beat_t b;
		b = '{default: '0, weight: '{default: '0}};
		b.cmd         = CMD_WRITE;
		b.matrix_addr = addr[10:0];
		b.matrix_word = word;
		pending_beats.insert(pending_beats.size(), b);
		beats_queued++;
		if (addr < STORE_DEPTH) begin
			joint_filled[addr/12][addr%12] = 1'b1;
			if (joint_filled[addr/12] == 12'hFFF && !(addr/12 inside {complete_joints}))
				complete_joints.insert(complete_joints.size(), addr/12);
		end
	endtask

	task automatic push_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z,
			logic [27:0] js, logic [16:0] w0, logic [16:0] w1, logic [16:0] w2,
			logic [16:0] w3);
		cmd_beat_t b;
		b = '{default: '0, weight: '{default: '0}};
		b.cmd       = CMD_SKIN;
		b.pos_x     = x;
		b.pos_y     = y;
		b.pos_z     = z;
		b.joint_set = js;
		b.weight    = '{w0, w1, w2, w3};
		pending_beats.insert(pending_beats.size(), b);
		beats_queued++;
	endtask

	function automatic logic [31:0] rand_word();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4)
			return 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
		if (r < 6)
			return r[0] ? 32'h0001_0000 : 32'h0;
		return $urandom();
	endfunction

	function automatic logic [31:0] rand_pos();
		if ($urandom_range(0, 1))
			return 32'($signed($urandom_range(0, 1 << 25)) - (1 << 24));
		return $urandom();
	endfunction

	function automatic logic [16:0] rand_weight();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 17'd0;
		if (r == 1)
			return 17'd65536;
		return 17'($urandom_range(0, 65536));
	endfunction

	task automatic push_random_vertex();
		logic [27:0] js;
		logic [16:0] w [4];
		int          left;
		for (int k = 0; k < 4; k++)
			js[7*k +: 7] = 7'(complete_joints[$urandom_range(0, complete_joints.size() - 1)]);
		if ($urandom_range(0, 1)) begin
			left = 65536;
			for (int k = 0; k < 3; k++) begin
				w[k] = 17'($urandom_range(0, left));
				left -= w[k];
			end
			w[3] = 17'(left);
		end else begin
			for (int k = 0; k < 4; k++)
				w[k] = rand_weight();
		end
		push_vertex(rand_pos(), rand_pos(), rand_pos(), js, w[0], w[1], w[2], w[3]);
	endtask

	task automatic push_random_beats(int count);
		int r;
		int j;
		for (int n = 0; n < count; n++) begin
			burst_mode = ($urandom_range(0, 99) < 3) ? !burst_mode : burst_mode;
			r = $urandom_range(0, 99);
			if (r < 6) begin
				j = $urandom_range(0, JOINT_COUNT - 1);
				for (int e = 0; e < 12; e++)
					push_write(j*12 + e, rand_word());
			end else if (r < 14) begin
				push_write($urandom_range(0, STORE_DEPTH - 1), rand_word());
			end else if (r < 16) begin
				push_write($urandom_range(STORE_DEPTH, 2047), $urandom());
			end else begin
				push_random_vertex();
			end
		end
	endtask

	task automatic drain_then_config(logic value);
		while (pending_beats.size() != 0 || expected_positions.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		blend_on = value;
	endtask

	initial begin
		beats_queued  = 0;
		burst_mode    = 1'b0;
		blend_on      = 1'b1;
		for (int j = 0; j < JOINT_COUNT; j++)
			joint_filled[j] = '0;
		for (int a = 0; a < STORE_DEPTH; a++)
			skin_words[a] = '0;
		cfg_wr_en   = 1'b0;
		cfg_wr_data = 1'b0;
		arst_n      = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		drain_then_config(1'b1);

		// joint 127 identity, joint 0 extreme words
		for (int e = 0; e < 12; e++)
			push_write(127*12 + e, (e % 5 == 0) ? 32'h0001_0000 : 32'h0);
		for (int e = 0; e < 12; e++)
			push_write(e, e[0] ? 32'h8000_0000 : 32'h7FFF_FFFF);
		push_write(2047, 32'hDEAD_BEEF);
		push_vertex(32'h0003_8000, 32'hFFFF_0000, 32'h7FFF_FFFF, {4{7'd127}},
			17'd65536, 17'd0, 17'd0, 17'd0);
		push_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, {4{7'd127}},
			17'd65536, 17'd65536, 17'd65536, 17'd65536);
		push_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, {4{7'd0}},
			17'd65536, 17'd65536, 17'd65536, 17'd65536);
		push_vertex(32'h0, 32'h0, 32'h0, {7'd0, 7'd127, 7'd0, 7'd127},
			17'd1, 17'd65535, 17'd32768, 17'd0);
		push_vertex(32'h1234_5678, 32'hFEDC_BA98, 32'h0000_0001, {7'd127, 7'd0, 7'd127, 7'd0},
			17'd0, 17'd0, 17'd0, 17'd0);

		push_random_beats(420);
		drain_then_config(1'b0);
		push_random_beats(240);
		drain_then_config(1'b1);
		push_random_beats(340);

		while (pending_beats.size() != 0 || expected_positions.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("ran %0d beats: %0d vertices and %0d matrix writes over three enable phases",
			beats_queued, vertex_count, write_count);
		$display("%0d results checked, %0d saturated, %0d joints fully loaded",
			checked_count, sat_count, complete_joints.size());
		if (error_count == 0)
			$display("** linear_blend_skinning_unit: PASSED **");
		else
			$display("** linear_blend_skinning_unit: FAILED **");
		$finish;
	end

endmodule
